// ----- design/gopx_pkg.sv -----
`default_nettype none

package gopx_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CELL_SIZE_W = 18;
   localparam int POS_W       = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_COST_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GRID_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CELL_SIZE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CLEAR_FRAMES   = 3'd5;

   localparam logic signed [7:0]   RST_COST_THRESHOLD = 8'sd65;
   localparam logic [10:0]         RST_GRID_WIDTH     = 11'd1024;
   localparam logic [17:0]         RST_CELL_SIZE      = 18'd3277;
   localparam logic [3:0]          RST_CLEAR_FRAMES   = 4'd5;

   // Cost code for a cell of unknown occupancy
   localparam logic signed [7:0]   COST_UNKNOWN = -8'sd1;

   typedef enum logic [1:0] {
      KIND_POINT       = 2'd0,
      KIND_FRAME_HIT   = 2'd1,
      KIND_FRAME_EMPTY = 2'd2,
      KIND_CLEAR_ALL   = 2'd3
   } kind_type;

   typedef struct packed {
      logic signed [7:0]  cost_threshold;
      logic [10:0]        grid_width;
      logic [17:0]        cell_size;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [3:0]         clear_frames;
   } cfg_type;

   typedef struct packed {
      logic       hit;
      logic       last;
      kind_type   status;
      logic [3:0] count;
   } stage_type;

endpackage

`default_nettype wire

// ----- design/gopx_if.sv -----
`default_nettype none

interface gopx_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] cost_value;
   logic              frame_end;

   modport source (output valid, cost_value, frame_end, input ready);
   modport sink   (input valid, cost_value, frame_end, output ready);
endinterface

interface gopx_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic signed [31:0] x_pos;
   logic signed [31:0] y_pos;
   logic [3:0]         empty_count;
   logic               run_last;

   modport source (output valid, kind, x_pos, y_pos, empty_count, run_last, input ready);
   modport sink   (input valid, kind, x_pos, y_pos, empty_count, run_last, output ready);
endinterface

interface gopx_csr_if;
   logic                              valid;
   logic                              ready;
   logic [gopx_pkg::CSR_INDEX_W-1:0]  index;
   logic [gopx_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ----- design/grid_obstacle_point_extractor_core.sv -----
`default_nettype none

// Grid obstacle point extractor. Feed occupancy-grid cells in row-major order,
// one signed cost per req transaction, with frame_end set on the last cell of
// a frame. A cell whose cost is strictly above cost_threshold (the unknown
// cost -1 never counts) yields a kind 0 point at the cell centre,
// origin + (index + 0.5) * cell_size, signed Q15.16, saturated. The last cell
// of a frame yields one status after any point of its own: kind 1 when the
// frame had obstacles, kind 2 with the running empty-frame count, or kind 3
// (clear-all) when clear_frames consecutive empty frames have been seen.
// run_last marks the final rsp transaction caused by each cell. Throughput is
// one cell per clock while the result side keeps up; the single result
// register sets the output side at one result per clock, so a last cell that
// is also an obstacle sends its point and then its status, holding req ready
// low while the point goes out. The edge that accepts the req transaction
// loads the scan stage (counters, classification, centre multipliers);
// the result register then loads through the centre adders and saturation
// once the output is free. Write the csr registers only while no cell is
// in flight; origin_x and origin_y are normally rewritten between frames.

module grid_obstacle_point_extractor_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   gopx_req_if.sink   req_link,
   gopx_rsp_if.source rsp_link,
   gopx_csr_if.sink   csr_link
);

   localparam int PX_W = $clog2(MAX_WIDTH) + 1 + gopx_pkg::CELL_SIZE_W;
   localparam int PY_W = $clog2(MAX_HEIGHT) + 1 + gopx_pkg::CELL_SIZE_W;

   gopx_pkg::cfg_type   cfg;
   gopx_pkg::stage_type stage;
   logic                stage_valid;
   logic                release_stage;
   logic [PX_W-1:0]     prod_x;
   logic [PY_W-1:0]     prod_y;

   // Register file: always ready, writes land at the next edge
   gopx_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_link),
      .cfg   (cfg)
   );

   // Track cell position and frame state, classify the cell, and
   // register the centre products
   gopx_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req           (req_link),
      .release_stage (release_stage),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .prod_x        (prod_x),
      .prod_y        (prod_y)
   );

   // Finish the centre, sequence point and status, drive the result register
   gopx_place #(
      .PX_W (PX_W),
      .PY_W (PY_W)
   ) u_place (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .prod_x        (prod_x),
      .prod_y        (prod_y),
      .release_stage (release_stage),
      .rsp           (rsp_link)
   );

   // Only a point can be followed by another result of the same cell
   a_mid_is_point: assert property (@(posedge clock) disable iff (reset)
      rsp_link.valid && !rsp_link.run_last |-> rsp_link.kind == gopx_pkg::KIND_POINT)
      else $error("non-final result is not a point");

   // Frame status carries no position
   a_status_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_link.valid && rsp_link.kind != gopx_pkg::KIND_POINT |->
         rsp_link.x_pos == 32'sd0 && rsp_link.y_pos == 32'sd0)
      else $error("frame status with nonzero position");

   // An empty-frame status always reports at least one empty frame
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_link.valid && rsp_link.kind == gopx_pkg::KIND_FRAME_EMPTY |->
         rsp_link.empty_count != 4'd0)
      else $error("empty frame status with zero count");

   // A held stage blocks new cells
   a_stage_blocks: assert property (@(posedge clock) disable iff (reset)
      stage_valid && !release_stage |-> !req_link.ready)
      else $error("cell accepted over a held stage");

endmodule

`default_nettype wire

// ----- design/gopx_csr.sv -----
`default_nettype none

module gopx_csr (
   input  logic              clock,
   input  logic              reset,
   gopx_csr_if.sink          csr,
   output gopx_pkg::cfg_type cfg
);

   gopx_pkg::cfg_type cfg_ff;
   gopx_pkg::cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            gopx_pkg::REG_COST_THRESHOLD: cfg_in.cost_threshold = csr.wdata[7:0];
            gopx_pkg::REG_GRID_WIDTH:     cfg_in.grid_width     = csr.wdata[10:0];
            gopx_pkg::REG_CELL_SIZE:      cfg_in.cell_size      = csr.wdata[17:0];
            gopx_pkg::REG_ORIGIN_X:       cfg_in.origin_x       = csr.wdata;
            gopx_pkg::REG_ORIGIN_Y:       cfg_in.origin_y       = csr.wdata;
            gopx_pkg::REG_CLEAR_FRAMES:   cfg_in.clear_frames   = csr.wdata[3:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cost_threshold <= gopx_pkg::RST_COST_THRESHOLD;
         cfg_ff.grid_width     <= gopx_pkg::RST_GRID_WIDTH;
         cfg_ff.cell_size      <= gopx_pkg::RST_CELL_SIZE;
         cfg_ff.origin_x       <= '0;
         cfg_ff.origin_y       <= '0;
         cfg_ff.clear_frames   <= gopx_pkg::RST_CLEAR_FRAMES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/gopx_scan.sv -----
`default_nettype none

module gopx_scan #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  gopx_pkg::cfg_type   cfg,
   gopx_req_if.sink            req,
   input  logic                release_stage,
   output logic                stage_valid,
   output gopx_pkg::stage_type stage,
   output logic [$clog2(MAX_WIDTH)+gopx_pkg::CELL_SIZE_W:0]  prod_x,
   output logic [$clog2(MAX_HEIGHT)+gopx_pkg::CELL_SIZE_W:0] prod_y
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PX_W  = COL_W + 1 + gopx_pkg::CELL_SIZE_W;
   localparam int PY_W  = ROW_W + 1 + gopx_pkg::CELL_SIZE_W;
   localparam int CMP_W = (COL_W + 1 > 12) ? COL_W + 1 : 12;
   localparam int RW1   = ROW_W + 1;

   logic [COL_W-1:0]    column_ff, column_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                obstacle_ff, obstacle_in;
   logic [3:0]          empty_run_ff, empty_run_in;
   logic                stage_valid_ff, stage_valid_in;
   gopx_pkg::stage_type stage_ff, stage_in;
   logic [PX_W-1:0]     prod_x_ff;
   logic [PY_W-1:0]     prod_y_ff;

   logic                accept;
   logic                hit;
   logic                obstacle_now;
   logic [3:0]          run_inc;
   logic [3:0]          clear_lim;
   logic [CMP_W-1:0]    width_raw;
   logic [CMP_W-1:0]    width_eff;
   logic [CMP_W-1:0]    column_inc;
   logic [RW1-1:0]      row_inc;

   assign req.ready   = !stage_valid_ff || release_stage;
   assign accept      = req.valid && req.ready;
   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;
   assign prod_x      = prod_x_ff;
   assign prod_y      = prod_y_ff;

   // Unknown cells never qualify, whatever the threshold
   assign hit = (req.cost_value > cfg.cost_threshold) &&
                (req.cost_value != gopx_pkg::COST_UNKNOWN);
   assign obstacle_now = obstacle_ff || hit;
   assign run_inc      = empty_run_ff + 4'd1;
   assign clear_lim    = (cfg.clear_frames == 4'd0) ? 4'd1 : cfg.clear_frames;

   assign width_raw = CMP_W'(cfg.grid_width);
   always_comb begin
      if (width_raw == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_raw > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
   end

   assign column_inc = CMP_W'(column_ff) + CMP_W'(1);
   assign row_inc    = RW1'(row_ff) + RW1'(1);

   always_comb begin
      column_in      = column_ff;
      row_in         = row_ff;
      obstacle_in    = obstacle_ff;
      empty_run_in   = empty_run_ff;
      stage_valid_in = release_stage ? 1'b0 : stage_valid_ff;
      stage_in       = stage_ff;

      if (accept) begin
         stage_valid_in  = hit || req.frame_end;
         stage_in.hit    = hit;
         stage_in.last   = req.frame_end;
         stage_in.status = gopx_pkg::KIND_FRAME_HIT;
         stage_in.count  = 4'd0;
         obstacle_in     = obstacle_now;

         if (req.frame_end) begin
            if (obstacle_now) begin
               empty_run_in = 4'd0;
            end else if (run_inc >= clear_lim) begin
               stage_in.status = gopx_pkg::KIND_CLEAR_ALL;
               empty_run_in    = 4'd0;
            end else begin
               stage_in.status = gopx_pkg::KIND_FRAME_EMPTY;
               stage_in.count  = run_inc;
               empty_run_in    = run_inc;
            end
            column_in   = '0;
            row_in      = '0;
            obstacle_in = 1'b0;
         end else if (column_inc >= width_eff) begin
            column_in = '0;
            row_in    = (row_inc >= RW1'(MAX_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];
         end else begin
            column_in = column_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         row_ff         <= '0;
         obstacle_ff    <= 1'b0;
         empty_run_ff   <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         column_ff      <= column_in;
         row_ff         <= row_in;
         obstacle_ff    <= obstacle_in;
         empty_run_ff   <= empty_run_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   // Cell centre times two: (2*index+1) * cell_size, from the counters as held
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (accept) begin
         prod_x_ff <= PX_W'({column_ff, 1'b1}) * PX_W'(cfg.cell_size);
         prod_y_ff <= PY_W'({row_ff, 1'b1}) * PY_W'(cfg.cell_size);
      end
   end

endmodule

`default_nettype wire

// ----- design/gopx_centre.sv -----
`default_nettype none

module gopx_centre #(
   parameter int PROD_W = 29
) (
   input  logic signed [gopx_pkg::POS_W-1:0] origin,
   input  logic [PROD_W-1:0]                 prod,
   output logic signed [gopx_pkg::POS_W-1:0] pos
);

   localparam int SUM_W = ((PROD_W > gopx_pkg::POS_W) ? PROD_W : gopx_pkg::POS_W) + 2;
   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(2147483647);
   localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

   logic [PROD_W:0]          off_full;
   logic [SUM_W-1:0]         off_ext;
   logic signed [SUM_W-1:0]  origin_ext;
   logic signed [SUM_W-1:0]  sum;

   // Halve with round half up
   assign off_full   = {1'b0, prod} + {{PROD_W{1'b0}}, 1'b1};
   assign off_ext    = SUM_W'(off_full[PROD_W:1]);
   assign origin_ext = SUM_W'(origin);
   assign sum        = origin_ext + $signed(off_ext);

   always_comb begin
      if (sum > POS_MAX) begin
         pos = 32'sh7FFF_FFFF;
      end else if (sum < POS_MIN) begin
         pos = 32'sh8000_0000;
      end else begin
         pos = sum[gopx_pkg::POS_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- design/gopx_place.sv -----
`default_nettype none

module gopx_place #(
   parameter int PX_W = 29,
   parameter int PY_W = 29
) (
   input  logic                clock,
   input  logic                reset,
   input  gopx_pkg::cfg_type   cfg,
   input  logic                stage_valid,
   input  gopx_pkg::stage_type stage,
   input  logic [PX_W-1:0]     prod_x,
   input  logic [PY_W-1:0]     prod_y,
   output logic                release_stage,
   gopx_rsp_if.source          rsp
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               point_sent_ff, point_sent_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] y_ff, y_in;
   logic [3:0]         count_ff, count_in;
   logic               last_ff, last_in;

   logic               out_free;
   logic               send;
   logic               emit_point;
   logic signed [31:0] centre_x;
   logic signed [31:0] centre_y;

   gopx_centre #(.PROD_W(PX_W)) u_centre_x (
      .origin (cfg.origin_x),
      .prod   (prod_x),
      .pos    (centre_x)
   );

   gopx_centre #(.PROD_W(PY_W)) u_centre_y (
      .origin (cfg.origin_y),
      .prod   (prod_y),
      .pos    (centre_y)
   );

   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign send          = stage_valid && out_free;
   assign emit_point    = stage.hit && !point_sent_ff;
   // Hold the stage when its point goes out ahead of the frame status
   assign release_stage = send && !(emit_point && stage.last);

   always_comb begin
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      point_sent_in = point_sent_ff;
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      count_in      = count_ff;
      last_in       = last_ff;
      if (send) begin
         rsp_valid_in  = 1'b1;
         point_sent_in = !release_stage;
         if (emit_point) begin
            kind_in  = gopx_pkg::KIND_POINT;
            x_in     = centre_x;
            y_in     = centre_y;
            count_in = 4'd0;
            last_in  = !stage.last;
         end else begin
            kind_in  = stage.status;
            x_in     = '0;
            y_in     = '0;
            count_in = stage.count;
            last_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         point_sent_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         point_sent_ff <= point_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.kind        = kind_ff;
   assign rsp.x_pos       = x_ff;
   assign rsp.y_pos       = y_ff;
   assign rsp.empty_count = count_ff;
   assign rsp.run_last    = last_ff;

endmodule

`default_nettype wire

// ----- tb/tb_grid_obstacle_point_extractor_core.sv -----
module tb_grid_obstacle_point_extractor_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      CLOCK_PERIOD = 8;
   localparam int      GRID_MAX_W   = 1024;
   localparam int      GRID_MAX_H   = 1024;
   localparam longint  POS_HI       = 64'sd2147483647;
   localparam longint  POS_LO       = -64'sd2147483648;
   localparam int      RANDOM_CELLS = 560;

   // One rsp transaction as the block should present it
   typedef struct {
      gopx_pkg::kind_type kind;
      logic signed [31:0] x_pos;
      logic signed [31:0] y_pos;
      logic [3:0]         count;
      logic               last;
   } obstacle_report_type;

   logic clock = 1'b0;
   logic reset;

   gopx_req_if req_bus ();
   gopx_rsp_if rsp_bus ();
   gopx_csr_if csr_bus ();

   grid_obstacle_point_extractor_core #(
      .MAX_WIDTH (GRID_MAX_W),
      .MAX_HEIGHT(GRID_MAX_H)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_link(req_bus),
      .rsp_link(rsp_bus),
      .csr_link(csr_bus)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the csr registers
   logic signed [7:0]  cfg_thr;
   logic [10:0]        cfg_width;
   logic [17:0]        cfg_cell;
   logic signed [31:0] cfg_ox;
   logic signed [31:0] cfg_oy;
   logic [3:0]         cfg_clear;

   // Scan state of the grid walk
   int unsigned scan_col;
   int unsigned scan_row;
   bit          frame_hit;
   logic [3:0]  empty_run;

   obstacle_report_type obstacle_reports[$];

   int faults;
   int cells_sent;
   bit req_gaps;
   bit rsp_gaps;
   int ready_hold;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Clamp the programmed width the same way the scan counters see it
   function automatic int unsigned grid_cols(input logic [10:0] width);
      if (width == 0) return 1;
      if (width > GRID_MAX_W) return GRID_MAX_W;
      return width;
   endfunction

   // Centre of cell idx along one axis: origin + (idx + 0.5) * cell_size,
   // half rounded up, then clamped to the signed 32-bit range
   function automatic logic signed [31:0] cell_centre(input logic signed [31:0] base,
                                                       input int unsigned idx);
      longint offset;
      longint sum;
      offset = ((longint'(idx) * 2 + 1) * longint'(cfg_cell) + 1) >>> 1;
      sum    = longint'(base) + offset;
      if (sum > POS_HI)
         sum = POS_HI;
      else if (sum < POS_LO)
         sum = POS_LO;
      return sum[31:0];
   endfunction

   // Advance the scan by one accepted cell and queue what it must produce
   function automatic void extract_cell(input logic signed [7:0] cost, input logic last);
      obstacle_report_type out [2];
      int                  n;
      int unsigned         cols;
      logic [3:0]          run;
      logic [3:0]          limit;
      n     = 0;
      cols  = grid_cols(cfg_width);
      limit = (cfg_clear == 0) ? 4'd1 : cfg_clear;

      // The unknown cost never counts, whatever the threshold
      if (cost > cfg_thr && cost != gopx_pkg::COST_UNKNOWN) begin
         out[n] = '{gopx_pkg::KIND_POINT, cell_centre(cfg_ox, scan_col),
                    cell_centre(cfg_oy, scan_row), 4'd0, 1'b0};
         n++;
         frame_hit = 1'b1;
      end

      if (last) begin
         // Frame status follows the cell's own point
         if (frame_hit) begin
            empty_run = 4'd0;
            out[n]    = '{gopx_pkg::KIND_FRAME_HIT, 32'sd0, 32'sd0, 4'd0, 1'b0};
         end else begin
            run = empty_run + 4'd1;
            if (run >= limit) begin
               empty_run = 4'd0;
               out[n]    = '{gopx_pkg::KIND_CLEAR_ALL, 32'sd0, 32'sd0, 4'd0, 1'b0};
            end else begin
               empty_run = run;
               out[n]    = '{gopx_pkg::KIND_FRAME_EMPTY, 32'sd0, 32'sd0, run, 1'b0};
            end
         end
         n++;
         scan_col  = 0;
         scan_row  = 0;
         frame_hit = 1'b0;
      end else if (scan_col + 1 >= cols) begin
         // Wrap the column, and the row after the tallest grid
         scan_col = 0;
         scan_row = (scan_row + 1 >= GRID_MAX_H) ? 0 : scan_row + 1;
      end else begin
         scan_col++;
      end

      if (n > 0)
         out[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++)
         obstacle_reports = {obstacle_reports, out[i]};
   endfunction

   function automatic void apply_reg(input logic [gopx_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [gopx_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         gopx_pkg::REG_COST_THRESHOLD: cfg_thr   = data[7:0];
         gopx_pkg::REG_GRID_WIDTH:     cfg_width = data[10:0];
         gopx_pkg::REG_CELL_SIZE:      cfg_cell  = data[17:0];
         gopx_pkg::REG_ORIGIN_X:       cfg_ox    = data;
         gopx_pkg::REG_ORIGIN_Y:       cfg_oy    = data;
         gopx_pkg::REG_CLEAR_FRAMES:   cfg_clear = data[3:0];
         default: ;
      endcase
   endfunction

   // Cost that does or does not beat the current threshold, within -1..100
   function automatic logic signed [7:0] pick_cost(input bit hit);
      int bot;
      int top;
      bot = (int'(cfg_thr) + 1 < 0) ? 0 : int'(cfg_thr) + 1;
      top = (int'(cfg_thr) > 100) ? 100 : int'(cfg_thr);
      if (hit && bot <= 100)
         return 8'($urandom_range(100, bot));
      if (top < -1 || $urandom_range(3) == 0)
         return gopx_pkg::COST_UNKNOWN;
      return 8'(int'($urandom_range(top + 1, 0)) - 1);
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Offer one cell, idling first at random; leave valid high on return so
   // back-to-back cells stream without a bubble
   task automatic send_cell(input logic signed [7:0] cost, input logic last);
      @(negedge clock);
      while (req_gaps && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cost_value <= cost;
      req_bus.frame_end  <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      extract_cell(cost, last);
      cells_sent++;
   endtask

   task automatic write_reg(input logic [gopx_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [gopx_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_reg(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Stop offering cells and wait until every queued report has come out.
   // A cell without any result may still sit in the two-stage pipe, so
   // keep idling before touching the registers.
   task automatic drain_pipeline;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (obstacle_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_grid(input logic [31:0] thr, input logic [31:0] width,
                               input logic [31:0] cell_res, input logic [31:0] ox,
                               input logic [31:0] oy, input logic [31:0] clear);
      drain_pipeline();
      write_reg(gopx_pkg::REG_COST_THRESHOLD, thr);
      write_reg(gopx_pkg::REG_GRID_WIDTH, width);
      write_reg(gopx_pkg::REG_CELL_SIZE, cell_res);
      write_reg(gopx_pkg::REG_ORIGIN_X, ox);
      write_reg(gopx_pkg::REG_ORIGIN_Y, oy);
      write_reg(gopx_pkg::REG_CLEAR_FRAMES, clear);
   endtask

   // Result side: stall at random, or hold off for a counted stretch when
   // a test asks for it
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold--;
      end else if (rsp_gaps && $urandom_range(99) < 30) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_reports
      obstacle_report_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (obstacle_reports.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: unexpected rsp transaction kind %0d x %0d y %0d", $time,
                        rsp_bus.kind, rsp_bus.x_pos, rsp_bus.y_pos);
         end else begin
            want = obstacle_reports.pop_front();
            if (rsp_bus.kind !== want.kind || rsp_bus.x_pos !== want.x_pos ||
                rsp_bus.y_pos !== want.y_pos || rsp_bus.empty_count !== want.count ||
                rsp_bus.run_last !== want.last) begin
               faults++;
               if (faults <= 10) begin
                  $display("%0t: rsp mismatch, expected kind %0d x %0d y %0d count %0d last %0b",
                           $time, want.kind, want.x_pos, want.y_pos, want.count, want.last);
                  $display("%0t:                  got kind %0d x %0d y %0d count %0d last %0b",
                           $time, rsp_bus.kind, rsp_bus.x_pos, rsp_bus.y_pos,
                           rsp_bus.empty_count, rsp_bus.run_last);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: threshold edge, unknown cost, points on one row
   task automatic test_point_basics;
      send_cell(8'sd66, 1'b0);
      send_cell(8'sd65, 1'b0);
      send_cell(gopx_pkg::COST_UNKNOWN, 1'b0);
      send_cell(8'sd100, 1'b0);
      send_cell(8'sd0, 1'b0);
      // Last cell is itself an obstacle: point first, then the status
      send_cell(8'sd66, 1'b1);
   endtask

   // Empty-frame counting, clear-all, and a clear_frames of zero
   task automatic test_frame_status;
      program_grid(65, 2, 3277, 0, 0, 2);
      send_cell(8'sd0, 1'b1);
      send_cell(gopx_pkg::COST_UNKNOWN, 1'b1);
      send_cell(8'sd5, 1'b1);
      send_cell(8'sd100, 1'b1);
      send_cell(8'sd0, 1'b1);
      drain_pipeline();
      write_reg(gopx_pkg::REG_CLEAR_FRAMES, 0);
      send_cell(8'sd0, 1'b1);
      send_cell(8'sd0, 1'b1);
   endtask

   // Threshold below the unknown code, zero and oversized width,
   // largest cell size, and both origin extremes with saturation at the top
   task automatic test_extremes;
      program_grid(32'hFFFF_FF80, 0, 262143, 32'h7FFF_F000, 32'h8000_0000, 15);
      send_cell(gopx_pkg::COST_UNKNOWN, 1'b0);
      send_cell(8'sd0, 1'b0);
      send_cell(8'sd100, 1'b0);
      send_cell(gopx_pkg::COST_UNKNOWN, 1'b1);
      program_grid(99, 2047, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15);
      send_cell(8'sd99, 1'b0);
      send_cell(8'sd100, 1'b1);
   endtask

   // Shrink the width while the column sits past the new width
   task automatic test_width_change;
      program_grid(65, 4, 3277, 0, 0, 5);
      send_cell(8'sd0, 1'b0);
      send_cell(8'sd0, 1'b0);
      send_cell(8'sd0, 1'b0);
      drain_pipeline();
      write_reg(gopx_pkg::REG_GRID_WIDTH, 2);
      send_cell(8'sd70, 1'b0);
      send_cell(8'sd70, 1'b1);
   endtask

   // Hold off the result side while cells keep coming, so the block backs
   // up and drops req ready
   task automatic test_backpressure;
      program_grid(50, 8, 3277, 0, 0, 5);
      req_gaps = 1'b0;
      @(posedge clock);
      ready_hold = 80;
      for (int i = 0; i < 40; i++)
         send_cell(pick_cost(1'b1), i == 39);
      req_gaps = 1'b1;
   endtask

   // Random settings per phase, each phase a handful of well-formed frames
   // with random costs; some frames are cut short by an early frame_end
   task automatic test_random_frames;
      int          phase;
      int          start;
      int          frames;
      int          rows;
      int          cells;
      int          empty_pct;
      int          hit_pct;
      bit          hit_frame;
      logic [31:0] width;
      logic [31:0] cell_res;
      logic [31:0] ox;
      phase = 0;
      start = cells_sent;
      while (cells_sent - start < RANDOM_CELLS) begin
         case (phase)
            0: program_grid(-1, 1, 1, 32'h8000_0000, 32'h8000_0000, 1);
            1: program_grid(100, GRID_MAX_W, 262143, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15);
            default: begin
               case ($urandom_range(9))
                  0: width = 0;
                  1: width = GRID_MAX_W;
                  2: width = 2047;
                  3: width = $urandom_range(GRID_MAX_W - 1, 9);
                  default: width = $urandom_range(8, 1);
               endcase
               case ($urandom_range(5))
                  0: cell_res = 1;
                  1: cell_res = 262143;
                  default: cell_res = $urandom_range(262143, 1);
               endcase
               // Push the x origin near the top now and then to force clamping
               ox = ($urandom_range(3) == 0) ? 32'h7FFF_FFFF - $urandom_range(1 << 20)
                                             : $urandom();
               program_grid(32'(int'($urandom_range(101)) - 1), width, cell_res, ox,
                            $urandom(), $urandom_range(15));
            end
         endcase

         // Phase 3 runs with no idling on either side
         req_gaps  = (phase != 3);
         rsp_gaps  = (phase != 3);
         empty_pct = (phase % 3 == 1) ? 90 : 45;
         frames    = $urandom_range(8, 3);

         repeat (frames) begin
            if ($urandom_range(3) == 0) begin
               drain_pipeline();
               write_reg(gopx_pkg::REG_ORIGIN_X, $urandom());
               write_reg(gopx_pkg::REG_ORIGIN_Y, $urandom());
            end
            rows  = $urandom_range(3, 1);
            cells = (grid_cols(cfg_width) <= 16) ? grid_cols(cfg_width) * rows
                                                 : $urandom_range(24, 1);
            if ($urandom_range(9) == 0)
               cells = $urandom_range(cells, 1);
            hit_frame = $urandom_range(99) >= empty_pct;
            hit_pct   = $urandom_range(40, 5);
            for (int i = 0; i < cells; i++)
               send_cell(pick_cost(hit_frame && $urandom_range(99) < hit_pct), i == cells - 1);
         end
         phase++;
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cost_value = 8'sd0;
      req_bus.frame_end  = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = gopx_pkg::REG_COST_THRESHOLD;
      csr_bus.wdata      = '0;
      rsp_bus.ready      = 1'b0;
      faults             = 0;
      cells_sent         = 0;
      req_gaps           = 1'b1;
      rsp_gaps           = 1'b1;
      ready_hold         = 0;

      // Registers and scan state as they come out of reset
      cfg_thr   = gopx_pkg::RST_COST_THRESHOLD;
      cfg_width = gopx_pkg::RST_GRID_WIDTH;
      cfg_cell  = gopx_pkg::RST_CELL_SIZE;
      cfg_ox    = 32'sd0;
      cfg_oy    = 32'sd0;
      cfg_clear = gopx_pkg::RST_CLEAR_FRAMES;
      scan_col  = 0;
      scan_row  = 0;
      frame_hit = 1'b0;
      empty_run = 4'd0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_point_basics();
      test_frame_status();
      test_extremes();
      test_width_change();
      test_random_frames();
      test_backpressure();

      // Let the last reports out, then let the pipe idle before the verdict
      drain_pipeline();
      repeat (8) @(posedge clock);
      if (faults == 0 && obstacle_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
